// File: design/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

   localparam int COORD_WIDTH_DEFAULT = 18;

   localparam int RADIUS_WIDTH = 12;
   localparam int SCALE_WIDTH  = 10;
   localparam int FRAC_BITS    = 8;
   localparam int SCALED_WIDTH = RADIUS_WIDTH + SCALE_WIDTH - FRAC_BITS;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESIZE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS_SCALE  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_TOLERANCE = 2'd2;

   localparam logic [SCALE_WIDTH-1:0]  RADIUS_SCALE_RESET  = 10'd256;
   localparam logic [RADIUS_WIDTH-1:0] MIN_TOLERANCE_RESET = 12'd64;

   localparam logic KIND_SPHERE = 1'b0;
   localparam logic KIND_ATOM   = 1'b1;

   localparam logic [1:0] MUL_SEL_X = 2'd0;
   localparam logic [1:0] MUL_SEL_Y = 2'd1;
   localparam logic [1:0] MUL_SEL_Z = 2'd2;

   typedef struct packed {
      logic                    resize_mode;
      logic [SCALE_WIDTH-1:0]  radius_scale;
      logic [RADIUS_WIDTH-1:0] min_tolerance;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       load_sphere;
      logic       prepare;
      logic [1:0] mul_sel;
      logic       acc_clear;
      logic       acc_add;
      logic       root_step;
      logic       evaluate;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic last;
      logic removed;
      logic out_free;
   } status_type;

endpackage

// File: design/scs_ctrl.sv
`timescale 1ns / 1ps

module scs_ctrl
   import scs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int ROOT_WIDTH = COORD_WIDTH + 2;
   localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(ROOT_WIDTH - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SQX      = 4'd2;
   localparam logic [3:0] S_SQY      = 4'd3;
   localparam logic [3:0] S_SQZ      = 4'd4;
   localparam logic [3:0] S_SUM      = 4'd5;
   localparam logic [3:0] S_ROOT     = 4'd6;
   localparam logic [3:0] S_EVAL     = 4'd7;
   localparam logic [3:0] S_RESULT   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_SEL_X;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.kind == KIND_SPHERE) begin
               cmd.load_sphere = 1'b1;
               state_in = status.last ? S_RESULT : S_IDLE;
            end else if (status.removed) begin
               // atoms after removal are skipped
               state_in = status.last ? S_RESULT : S_IDLE;
            end else begin
               cmd.prepare = 1'b1;
               state_in    = S_SQX;
            end
         end
         S_SQX: begin
            cmd.mul_sel   = MUL_SEL_X;
            cmd.acc_clear = 1'b1;
            state_in      = S_SQY;
         end
         S_SQY: begin
            cmd.mul_sel = MUL_SEL_Y;
            cmd.acc_add = 1'b1;
            state_in    = S_SQZ;
         end
         S_SQZ: begin
            cmd.mul_sel = MUL_SEL_Z;
            cmd.acc_add = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.acc_add = 1'b1;
            step_in     = '0;
            state_in    = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = status.last ? S_RESULT : S_IDLE;
         end
         S_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: design/scs_datapath.sv
`timescale 1ns / 1ps

module scs_datapath
   import scs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic                          req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [RADIUS_WIDTH-1:0]       req_radius,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_remove_sphere,
   output logic [RADIUS_WIDTH-1:0]       rsp_new_tolerance,
   output logic                          rsp_modified
);

   localparam int CW  = COORD_WIDTH;
   localparam int MW  = CW + 1;          // magnitude of a coordinate difference
   localparam int PW  = 2 * MW;          // square of a magnitude
   localparam int RW  = CW + 2;          // root bits
   localparam int AW  = 2 * RW;          // sum of squares, also the radicand shifter
   localparam int EW  = RW + 1;          // overlap compare width
   localparam int MUL = RADIUS_WIDTH + SCALE_WIDTH;

   // captured item
   logic                    kind_ff, kind_in;
   logic                    last_ff, last_in;
   logic signed [CW-1:0]    px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [RADIUS_WIDTH-1:0] rad_ff, rad_in;

   // sphere state
   logic signed [CW-1:0]    sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [RADIUS_WIDTH-1:0] tol_ff, tol_in;
   logic                    removed_ff, removed_in;
   logic                    seen_ff, seen_in;

   // distance work
   logic [MW-1:0]           mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [SCALED_WIDTH-1:0] scaled_ff, scaled_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [AW-1:0]           acc_ff, acc_in;
   logic [RW-1:0]           root_ff, root_in;
   logic [RW+1:0]           rem_ff, rem_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic                    out_remove_ff, out_remove_in;
   logic [RADIUS_WIDTH-1:0] out_tol_ff, out_tol_in;
   logic                    out_mod_ff, out_mod_in;

   logic signed [CW:0] dx, dy, dz;
   logic [MW-1:0]      mul_op;
   logic [MUL-1:0]     scale_prod;
   logic [RW+3:0]      rem_shift, trial;
   logic [EW-1:0]      dist_e, tol_e, scaled_e, min_e;
   logic               clash, below_min;

   assign dx = {sx_ff[CW-1], sx_ff} - {px_ff[CW-1], px_ff};
   assign dy = {sy_ff[CW-1], sy_ff} - {py_ff[CW-1], py_ff};
   assign dz = {sz_ff[CW-1], sz_ff} - {pz_ff[CW-1], pz_ff};

   assign scale_prod = MUL'(rad_ff) * MUL'(cfg.radius_scale);

   always_comb begin
      case (cmd.mul_sel)
         MUL_SEL_Y: mul_op = my_ff;
         MUL_SEL_Z: mul_op = mz_ff;
         default:   mul_op = mx_ff;
      endcase
   end

   // one root bit per step, two radicand bits consumed from the top of acc
   assign rem_shift = {rem_ff, acc_ff[AW-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};

   assign dist_e    = EW'(root_ff);
   assign tol_e     = EW'(tol_ff);
   assign scaled_e  = EW'(scaled_ff);
   assign min_e     = EW'(cfg.min_tolerance);
   assign clash     = dist_e < (tol_e + scaled_e);
   assign below_min = dist_e < (scaled_e + min_e);

   always_comb begin
      kind_in    = kind_ff;
      last_in    = last_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      pz_in      = pz_ff;
      rad_in     = rad_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      sz_in      = sz_ff;
      tol_in     = tol_ff;
      removed_in = removed_ff;
      seen_in    = seen_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;
      mz_in      = mz_ff;
      scaled_in  = scaled_ff;
      prod_in    = PW'(mul_op) * PW'(mul_op);
      acc_in     = acc_ff;
      root_in    = root_ff;
      rem_in     = rem_ff;
      out_valid_in  = out_valid_ff;
      out_remove_in = out_remove_ff;
      out_tol_in    = out_tol_ff;
      out_mod_in    = out_mod_ff;

      if (cmd.capture) begin
         kind_in = req_kind;
         last_in = req_last;
         px_in   = req_pos_x;
         py_in   = req_pos_y;
         pz_in   = req_pos_z;
         rad_in  = req_radius;
      end

      if (cmd.load_sphere) begin
         sx_in      = px_ff;
         sy_in      = py_ff;
         sz_in      = pz_ff;
         tol_in     = rad_ff;
         removed_in = 1'b0;
         seen_in    = 1'b0;
      end

      if (cmd.prepare) begin
         mx_in     = dx[CW] ? MW'(-dx) : MW'(dx);
         my_in     = dy[CW] ? MW'(-dy) : MW'(dy);
         mz_in     = dz[CW] ? MW'(-dz) : MW'(dz);
         scaled_in = scale_prod[MUL-1:FRAC_BITS];
      end

      if (cmd.acc_clear) begin
         acc_in  = '0;
         root_in = '0;
         rem_in  = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + AW'(prod_ff);
      end else if (cmd.root_step) begin
         acc_in = {acc_ff[AW-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = (RW+2)'(rem_shift - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[RW+1:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end

      if (cmd.evaluate && clash) begin
         if (!cfg.resize_mode) begin
            removed_in = 1'b1;
         end else begin
            seen_in = 1'b1;
            if (below_min) begin
               removed_in = 1'b1;
            end else begin
               // tolerance minus overlap reduces to distance minus scaled radius
               tol_in = RADIUS_WIDTH'(dist_e - scaled_e);
            end
         end
      end

      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_remove_in = removed_ff;
         out_tol_in    = tol_ff;
         out_mod_in    = cfg.resize_mode ? seen_ff : removed_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff        <= '0;
         sy_ff        <= '0;
         sz_ff        <= '0;
         tol_ff       <= '0;
         removed_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sz_ff        <= sz_in;
         tol_ff       <= tol_in;
         removed_ff   <= removed_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      last_ff       <= last_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      pz_ff         <= pz_in;
      rad_ff        <= rad_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      mz_ff         <= mz_in;
      scaled_ff     <= scaled_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      root_ff       <= root_in;
      rem_ff        <= rem_in;
      out_remove_ff <= out_remove_in;
      out_tol_ff    <= out_tol_in;
      out_mod_ff    <= out_mod_in;
   end

   assign status.kind     = kind_ff;
   assign status.last     = last_ff;
   assign status.removed  = removed_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_remove_sphere = out_remove_ff;
   assign rsp_new_tolerance = out_tol_ff;
   assign rsp_modified      = out_mod_ff;

endmodule

// File: design/sphere_clash_shrink.sv
`timescale 1ns / 1ps
// Exclusion sphere clash test against a stream of atoms.
// req channel (valid/ready): kind 0 loads a sphere center and tolerance, kind 1
// is one atom with its van der Waals radius; last marks the final item of a sphere.
// rsp channel (valid/ready): one item per item with last set, carrying the keep or
// remove decision, the resulting tolerance and the modified flag.
// csr port: write-only, index 0 resize_mode, 1 radius_scale, 2 min_tolerance,
// to be written by the user only while the block is idle; the block has no check.
// One item is in flight at a time. A sphere item passes through a dispatch
// state before the next ready. An atom passes through dispatch, three squares
// through one shared multiplier, a sum and a digit-by-digit square root that
// settles one of COORD_WIDTH + 2 root bits per cycle, then an evaluate state.
// An atom after the sphere is removed is skipped without a distance check.
// An item with last set then enters a result state that loads the output register.
// If rsp_ready is low the result waits in the output register; the next item is
// still taken, and only the following result waits for the register to free.
// Reset is synchronous: sphere center at the origin, tolerance zero, flags
// clear, registers at their defaults (remove mode, scale 1.0, minimum 0.25 A).

module sphere_clash_shrink
   import scs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [RADIUS_WIDTH-1:0]       req_radius,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_remove_sphere,
   output logic [RADIUS_WIDTH-1:0]       rsp_new_tolerance,
   output logic                          rsp_modified,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RESIZE_MODE:   cfg_in.resize_mode   = csr_wdata[0];
            CSR_RADIUS_SCALE:  cfg_in.radius_scale  = csr_wdata[SCALE_WIDTH-1:0];
            CSR_MIN_TOLERANCE: cfg_in.min_tolerance = csr_wdata[RADIUS_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resize_mode   <= 1'b0;
         cfg_ff.radius_scale  <= RADIUS_SCALE_RESET;
         cfg_ff.min_tolerance <= MIN_TOLERANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scs_ctrl #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   scs_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_radius       (req_radius),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_remove_sphere(rsp_remove_sphere),
      .rsp_new_tolerance(rsp_new_tolerance),
      .rsp_modified     (rsp_modified)
   );

`ifndef SYNTHESIS
   // one item at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in work");

   // a result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending result");

   // a new sphere always starts kept
   a_sphere_fresh: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sphere |=> !status.removed)
      else $error("new sphere starts removed");
`endif

endmodule
